@@ hdl/pbu_pkg.sv @@
// Shared types and constants for the packet byte unstuffer.
// No dependencies; compile first.
`timescale 1ns / 1ps

package pbu_pkg;

    // Framing symbols on the serial link
    localparam logic [7:0] SYM_START = 8'h7a;
    localparam logic [7:0] SYM_END   = 8'h7b;
    localparam logic [7:0] SYM_CHAN  = 8'h7c;
    localparam logic [7:0] SYM_PESC  = 8'h7d;
    localparam logic [7:0] SYM_IDLE  = 8'h4a;
    localparam logic [7:0] SYM_XESC  = 8'h4d;
    localparam logic [7:0] ESC_FLIP  = 8'h20;
    localparam logic [7:0] CHAN_ZERO = 8'h00;

    // Status reported with every result transaction
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_START    = 3'd1,
        ST_BADCHAN  = 3'd2,
        ST_AFTEREND = 3'd3,
        ST_NOEND    = 3'd4,
        ST_NOSTART  = 3'd5
    } status_t;

endpackage

@@ hdl/pbu_ifs.sv @@
// Valid/ready channel interfaces for the packet byte unstuffer.
// Depends on pbu_pkg.
`timescale 1ns / 1ps

// Raw link bytes into the unstuffer
interface pbu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

// Decoded results out of the unstuffer
interface pbu_out_if import pbu_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    status_t    status;

    modport source (output valid, output data_byte, output data_valid, output last,
                    output status, input ready);
    modport sink   (input valid, input data_byte, input data_valid, input last,
                    input status, output ready);
endinterface

@@ hdl/packet_byte_unstuffer.sv @@
// Top level of the packet byte unstuffer: framing parser with stuffed-byte decode.
// Depends on pbu_pkg and the channel interfaces in pbu_ifs.sv.
`timescale 1ns / 1ps

//  channel     | dir | payload                                  | handshake
//  ------------+-----+------------------------------------------+-----------
//  in_stream   | in  | rx_byte[7:0], end_of_buffer              | valid/ready
//  out_stream  | out | data_byte[7:0], data_valid, last, status | valid/ready
//
// Every input transaction yields exactly one result transaction.
// Throughput is one byte per cycle when not stalled; a byte goes through the
// input register, then the decode logic into the result register. The parse
// mode register loops back through the decode logic, which sets this rate.
// A stalled output holds the result register; the input register still takes
// a byte while it is empty or moving on in the same cycle.
// rst_n clears the parse mode, the start flag and both valid flags.

module packet_byte_unstuffer import pbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pbu_in_if.sink    in_stream,
    pbu_out_if.source out_stream
);

    typedef enum logic [2:0] {
        MODE_HUNT     = 3'd0,
        MODE_BODY     = 3'd1,
        MODE_CHAN     = 3'd2,
        MODE_ESC      = 3'd3,
        MODE_TAIL     = 3'd4,
        MODE_TAIL_ESC = 3'd5
    } mode_t;

    // Input register stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eob_reg;

    // Parser state
    mode_t      mode_reg, mode_next;
    logic       seen_reg, seen_next;

    // Result register stage
    logic       out_valid_reg;
    logic [7:0] data_byte_reg, data_byte_next;
    logic       data_valid_reg, data_valid_next;
    logic       last_reg, last_next;
    status_t    status_reg, status_next;

    logic       out_free;
    logic       s1_adv;
    logic       in_take;

    // Result register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_stream.ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stream.ready = !s1_valid_reg || out_free;
    assign in_take  = in_stream.valid && in_stream.ready;

    // Decode one byte against the current parse mode
    always_comb
    begin
        data_byte_next  = 8'h00;
        data_valid_next = 1'b0;
        last_next       = 1'b0;
        status_next     = ST_NONE;
        mode_next       = mode_reg;
        seen_next       = seen_reg;

        unique case (mode_reg)
            MODE_HUNT:
            begin
                if (s1_byte_reg == SYM_START)
                begin
                    mode_next   = MODE_BODY;
                    seen_next   = 1'b1;
                    status_next = ST_START;
                end
            end
            MODE_BODY:
            begin
                case (s1_byte_reg) inside
                    SYM_START:
                    begin
                        // abandon the partial packet, open a new one
                        seen_next   = 1'b1;
                        status_next = ST_START;
                    end
                    SYM_CHAN:           mode_next = MODE_CHAN;
                    SYM_XESC, SYM_PESC: mode_next = MODE_ESC;
                    SYM_END:            mode_next = MODE_TAIL;
                    SYM_IDLE:           ;
                    default:
                    begin
                        data_byte_next  = s1_byte_reg;
                        data_valid_next = 1'b1;
                    end
                endcase
            end
            MODE_CHAN:
            begin
                if (s1_byte_reg == CHAN_ZERO)
                begin
                    mode_next = MODE_BODY;
                end
                else
                begin
                    mode_next   = MODE_HUNT;
                    status_next = ST_BADCHAN;
                end
            end
            MODE_ESC:
            begin
                data_byte_next  = s1_byte_reg ^ ESC_FLIP;
                data_valid_next = 1'b1;
                mode_next       = MODE_BODY;
            end
            MODE_TAIL:
            begin
                case (s1_byte_reg) inside
                    SYM_XESC, SYM_PESC: mode_next = MODE_TAIL_ESC;
                    SYM_IDLE, SYM_START, SYM_CHAN, SYM_END:
                    begin
                        mode_next   = MODE_HUNT;
                        status_next = ST_AFTEREND;
                    end
                    default:
                    begin
                        data_byte_next  = s1_byte_reg;
                        data_valid_next = 1'b1;
                        last_next       = 1'b1;
                        mode_next       = MODE_HUNT;
                    end
                endcase
            end
            MODE_TAIL_ESC:
            begin
                data_byte_next  = s1_byte_reg ^ ESC_FLIP;
                data_valid_next = 1'b1;
                last_next       = 1'b1;
                mode_next       = MODE_HUNT;
            end
            default:
            begin
                mode_next = MODE_HUNT;
            end
        endcase

        // End of buffer: flag missing start or unfinished packet, then rearm
        if (s1_eob_reg)
        begin
            if (!seen_next)
            begin
                status_next = ST_NOSTART;
            end
            else if (mode_next != MODE_HUNT && status_next != ST_BADCHAN &&
                     status_next != ST_AFTEREND)
            begin
                status_next = ST_NOEND;
            end
            mode_next = MODE_HUNT;
            seen_next = 1'b0;
        end
    end

    // Control: valid flags and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_HUNT;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                seen_reg      <= seen_next;
            end
            else if (out_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture input bytes, load decoded results
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_stream.rx_byte;
            s1_eob_reg  <= in_stream.end_of_buffer;
        end
        if (s1_adv)
        begin
            data_byte_reg  <= data_byte_next;
            data_valid_reg <= data_valid_next;
            last_reg       <= last_next;
            status_reg     <= status_next;
        end
    end

    assign out_stream.valid      = out_valid_reg;
    assign out_stream.data_byte  = data_byte_reg;
    assign out_stream.data_valid = data_valid_reg;
    assign out_stream.last       = last_reg;
    assign out_stream.status     = status_reg;

`ifndef SYNTHESIS
    // A byte closing a packet always carries decoded data
    a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!last_reg || data_valid_reg))
        else $error("last set without a decoded data byte");

    // Dropped positions report a zero data byte
    a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !data_valid_reg) |-> (data_byte_reg == 8'h00))
        else $error("nonzero data byte without data_valid");

    // End of buffer rearms the parser
    a_eob_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_eob_reg) |=> (mode_reg == MODE_HUNT && !seen_reg))
        else $error("parser not rearmed after end of buffer");

    // Input backpressure only comes from a held input register
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stream.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room available");
`endif

endmodule
